[rtl/mrl_pkg.sv]
package mrl_pkg;

   localparam int IDENT_W = 16;
   localparam int RANK_W  = 4;

endpackage

[rtl/mru_recency_list.sv]
// Most-recently-used list of identifiers, held in a ring of LIST_DEPTH slots with a pointer to
// the newest slot. Each transaction on req_ searches the slots from slot 0 upward for req_ident
// and takes the first match. On a hit the newer entries slide down one place, the identifier
// becomes newest and rsp_hit_rank gives its recency rank (low 4 bits). On a miss the pointer
// advances and the oldest entry is replaced and returned on rsp_evicted_ident. After reset
// every slot holds identifier 0. One transaction is in work at a time, and req_ready is high
// only while the block is idle. All work goes through a list memory with one read port and one
// write port and a single comparator: the search stops at the first match, a hit then slides
// the newer entries down one by one, a miss reads and replaces the oldest entry, and then the
// result is handed to the rsp_ register, which waits while an earlier response is still not
// taken. The next transaction is taken in the idle cycle after that.
module mru_recency_list #(
   parameter int LIST_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mrl_pkg::IDENT_W-1:0]  req_ident,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic [mrl_pkg::RANK_W-1:0]   rsp_hit_rank,
   output logic [mrl_pkg::IDENT_W-1:0]  rsp_evicted_ident
);

   localparam int IDX_W = $clog2(LIST_DEPTH);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(LIST_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_EVICT_RD,
      ST_EVICT_WR,
      ST_RESP
   } state_type;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] slot);
      return (slot == LAST_SLOT) ? '0 : slot + 1'b1;
   endfunction

   // list memory, valid bits stand in for the clear to zero at reset
   logic [mrl_pkg::IDENT_W-1:0] mem [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]       slot_valid_ff;
   logic [mrl_pkg::IDENT_W-1:0] rd_data_ff;
   logic                        rd_valid_ff;
   logic [IDX_W-1:0]            rd_addr;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [mrl_pkg::IDENT_W-1:0] wr_data;
   logic [mrl_pkg::IDENT_W-1:0] entry;

   state_type                   state_ff, state_in;
   logic [mrl_pkg::IDENT_W-1:0] ident_ff, ident_in;
   logic [IDX_W-1:0]            newest_ff, newest_in;
   logic [IDX_W-1:0]            scan_ff, scan_in;
   logic [IDX_W-1:0]            cmp_slot_ff, cmp_slot_in;
   logic                        cmp_pending_ff, cmp_pending_in;
   logic [IDX_W-1:0]            pos_ff, pos_in;
   logic                        hit_ff, hit_in;
   logic [mrl_pkg::RANK_W-1:0]  rank_ff, rank_in;
   logic [mrl_pkg::IDENT_W-1:0] evict_ff, evict_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_hit_ff, rsp_hit_in;
   logic [mrl_pkg::RANK_W-1:0]  rsp_rank_ff, rsp_rank_in;
   logic [mrl_pkg::IDENT_W-1:0] rsp_evict_ff, rsp_evict_in;
   logic [IDX_W:0]              rank_full;
   logic [31:0]                 rank_wide;

   assign entry = rd_valid_ff ? rd_data_ff : '0;

   // rank = (newest - slot) mod depth
   always_comb begin
      if (newest_ff >= cmp_slot_ff) begin
         rank_full = {1'b0, newest_ff} - {1'b0, cmp_slot_ff};
      end else begin
         rank_full = {1'b0, newest_ff} + (IDX_W+1)'(LIST_DEPTH) - {1'b0, cmp_slot_ff};
      end
      rank_wide = 32'(rank_full);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            slot_valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= slot_valid_ff[rd_addr] && !(wr_en && (wr_addr == rd_addr));
      end
   end

   always_comb begin
      state_in       = state_ff;
      ident_in       = ident_ff;
      newest_in      = newest_ff;
      scan_in        = scan_ff;
      cmp_slot_in    = cmp_slot_ff;
      cmp_pending_in = cmp_pending_ff;
      pos_in         = pos_ff;
      hit_in         = hit_ff;
      rank_in        = rank_ff;
      evict_in       = evict_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_rank_in    = rsp_rank_ff;
      rsp_evict_in   = rsp_evict_ff;
      rd_addr        = scan_ff;
      wr_en          = 1'b0;
      wr_addr        = pos_ff;
      wr_data        = ident_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ident_in       = req_ident;
               scan_in        = '0;
               cmp_pending_in = 1'b0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read of one slot overlaps the compare of the slot before it
            rd_addr        = scan_ff;
            scan_in        = ring_next(scan_ff);
            cmp_slot_in    = scan_ff;
            cmp_pending_in = 1'b1;
            if (cmp_pending_ff && (entry == ident_ff)) begin
               hit_in   = 1'b1;
               rank_in  = rank_wide[mrl_pkg::RANK_W-1:0];
               evict_in = '0;
               pos_in   = cmp_slot_ff;
               state_in = ST_SHIFT_RD;
            end else if (cmp_pending_ff && (cmp_slot_ff == LAST_SLOT)) begin
               hit_in    = 1'b0;
               rank_in   = '0;
               newest_in = ring_next(newest_ff);
               pos_in    = ring_next(newest_ff);
               state_in  = ST_EVICT_RD;
            end
         end
         ST_SHIFT_RD: begin
            rd_addr = ring_next(pos_ff);
            if (pos_ff == newest_ff) begin
               wr_en    = 1'b1;
               wr_addr  = newest_ff;
               wr_data  = ident_ff;
               state_in = ST_RESP;
            end else begin
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = entry;
            pos_in   = ring_next(pos_ff);
            state_in = ST_SHIFT_RD;
         end
         ST_EVICT_RD: begin
            rd_addr  = pos_ff;
            state_in = ST_EVICT_WR;
         end
         ST_EVICT_WR: begin
            evict_in = entry;
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = ident_ff;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_rank_in  = rank_ff;
               rsp_evict_in = evict_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         newest_ff      <= '0;
         cmp_pending_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         newest_ff      <= newest_in;
         cmp_pending_ff <= cmp_pending_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      ident_ff     <= ident_in;
      scan_ff      <= scan_in;
      cmp_slot_ff  <= cmp_slot_in;
      pos_ff       <= pos_in;
      hit_ff       <= hit_in;
      rank_ff      <= rank_in;
      evict_ff     <= evict_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_evict_ff <= rsp_evict_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_hit_rank      = rsp_rank_ff;
   assign rsp_evicted_ident = rsp_evict_ff;

endmodule
